>>> design/tinted_sprite_pixel_compositor_defines.svh
// Assertion macros for the tinted sprite compositor.
`ifndef TINTED_SPRITE_PIXEL_COMPOSITOR_DEFINES_SVH
`define TINTED_SPRITE_PIXEL_COMPOSITOR_DEFINES_SVH

// Property holds at every rising clock edge out of reset.
`define TSPC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tspc: assertion failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define TSPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tspc: implication failed");

// Antecedent in one cycle implies consequent in the next.
`define TSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tspc: next-cycle implication failed");

`endif

>>> design/tspc_pkg.sv
`default_nettype none
package tspc_pkg;

  // Configuration register indices
  localparam logic [7:0] CfgTintWord   = 8'd0;
  localparam logic [7:0] CfgGlobalAlpha = 8'd1;

  localparam logic [31:0] TintReset  = 32'h00FF_FFFF;
  localparam logic [8:0]  GaReset    = 9'd256;
  localparam logic [7:0]  SolidTag   = 8'd1;
  localparam logic [15:0] RoundBias  = 16'd128;
  localparam logic [7:0]  AlphaFull  = 8'hFF;

  // After alpha scaling
  typedef struct packed {
    logic [7:0]  alpha;
    logic [23:0] texel_rgb;
    logic [23:0] dst;
    logic [23:0] tint_rgb;
    logic        solid;
  } tspc_s1_t;

  // After tinting
  typedef struct packed {
    logic [7:0]  alpha;
    logic [23:0] colour;
    logic [23:0] dst;
  } tspc_s2_t;

  // Blend products, biased for rounding
  typedef struct packed {
    logic [2:0][15:0] t_src;
    logic [2:0][15:0] t_dst;
    logic [23:0]      colour;
    logic [23:0]      dst;
    logic             zero;
    logic             full;
  } tspc_s3_t;

  // Rounded divide by 255 from a biased product t = x*k + 128
  function automatic logic [7:0] mul255_round(input logic [15:0] t);
    logic [16:0] s;
    s = {1'b0, t} + {9'd0, t[15:8]};
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

>>> design/tspc_alpha.sv
`default_nettype none
module tspc_alpha (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [31:0]      texel_argb_i,
  input  wire logic [23:0]      dest_pixel_i,
  input  wire logic [31:0]      tint_word_i,
  input  wire logic [8:0]       global_alpha_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output tspc_pkg::tspc_s1_t    data_o
);
  import tspc_pkg::*;

  logic        valid_q;
  tspc_s1_t    data_q, data_d;
  logic [15:0] prod;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod = {8'd0, texel_argb_i[31:24]} * {8'd0, global_alpha_i[7:0]};
    data_d.texel_rgb = texel_argb_i[23:0];
    data_d.dst       = dest_pixel_i;
    data_d.tint_rgb  = tint_word_i[23:0];
    data_d.solid     = (tint_word_i[31:24] == SolidTag);
    // 256 and above leave the texel alpha alone
    data_d.alpha     = global_alpha_i[8] ? texel_argb_i[31:24] : prod[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

>>> design/tspc_tint.sv
`default_nettype none
module tspc_tint (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire tspc_pkg::tspc_s1_t data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output tspc_pkg::tspc_s2_t    data_o
);
  import tspc_pkg::*;

  logic        valid_q;
  tspc_s2_t    data_q, data_d;
  logic [2:0][15:0] t;
  logic [2:0][7:0]  tinted;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t[c] = {8'd0, data_i.texel_rgb[c*8 +: 8]} * {8'd0, data_i.tint_rgb[c*8 +: 8]}
             + RoundBias;
      tinted[c] = mul255_round(t[c]);
    end
    data_d.alpha  = data_i.alpha;
    data_d.dst    = data_i.dst;
    data_d.colour = data_i.solid ? data_i.tint_rgb : tinted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

>>> design/tspc_blend.sv
`default_nettype none
module tspc_blend (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire tspc_pkg::tspc_s2_t data_i,
  output logic                  mid_valid_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [23:0]           new_pixel_o,
  output logic                  write_enable_o
);
  import tspc_pkg::*;

  logic        mid_valid_q, out_valid_q;
  logic        mid_ready;
  tspc_s3_t    mid_q, mid_d;
  logic [7:0]  na;
  logic [23:0] blended;
  logic [8:0]  sum;
  logic [23:0] pixel_q, pixel_d;
  logic        we_q;

  assign mid_ready = !out_valid_q || ready_i;
  assign ready_o   = !mid_valid_q || mid_ready;

  // Products stage
  always_comb begin
    na = AlphaFull - data_i.alpha;
    for (int c = 0; c < 3; c++) begin
      mid_d.t_src[c] = {8'd0, data_i.colour[c*8 +: 8]} * {8'd0, data_i.alpha} + RoundBias;
      mid_d.t_dst[c] = {8'd0, data_i.dst[c*8 +: 8]} * {8'd0, na} + RoundBias;
    end
    mid_d.colour = data_i.colour;
    mid_d.dst    = data_i.dst;
    mid_d.zero   = (data_i.alpha == 8'd0);
    mid_d.full   = (data_i.alpha == AlphaFull);
  end

  // Rounding and sum stage
  always_comb begin
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      sum = {1'b0, mul255_round(mid_q.t_src[c])} + {1'b0, mul255_round(mid_q.t_dst[c])};
      blended[c*8 +: 8] = sum[7:0];
    end
    if (mid_q.zero) begin
      pixel_d = mid_q.dst;
    end else if (mid_q.full) begin
      pixel_d = mid_q.colour;
    end else begin
      pixel_d = blended;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mid_valid_q <= valid_i;
      end
      if (mid_ready) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mid_q <= mid_d;
    end
    if (mid_ready && mid_valid_q) begin
      pixel_q <= pixel_d;
      we_q    <= !mid_q.zero;
    end
  end

  assign mid_valid_o    = mid_valid_q;
  assign valid_o        = out_valid_q;
  assign new_pixel_o    = pixel_q;
  assign write_enable_o = we_q;
endmodule
`default_nettype wire

>>> design/tinted_sprite_pixel_compositor.sv
// Tinted sprite pixel compositor: blends one ARGB texel, tinted or replaced by a solid
// colour and scaled by a global opacity, over a 24-bit destination pixel. One pixel per
// clock is sustained unless the output stalls; each transaction passes through the
// registered stages alpha scale, tint multiply, blend products, rounding and sum.
// The 8x8 multipliers sit in the first three stages: one, three and six of them.
// A stalled output holds its pixel while the stages behind it keep filling.
// Configuration writes are taken in any cycle and should be made only with the pipeline
// empty; write_enable low marks a fully transparent texel.
`default_nettype none
`include "tinted_sprite_pixel_compositor_defines.svh"
module tinted_sprite_pixel_compositor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] texel_argb_i,
  input  wire logic [23:0] dest_pixel_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      new_pixel_o,
  output logic             write_enable_o
);
  import tspc_pkg::*;

  logic [31:0] tint_q;
  logic [8:0]  ga_q;
  logic        s1_valid, s1_ready, s2_valid, s2_ready, s3_valid;
  tspc_s1_t    s1_data;
  tspc_s2_t    s2_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q <= TintReset;
      ga_q   <= GaReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTintWord:    tint_q <= cfg_data_i;
        CfgGlobalAlpha: ga_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  tspc_alpha u_alpha (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .texel_argb_i   (texel_argb_i),
    .dest_pixel_i   (dest_pixel_i),
    .tint_word_i    (tint_q),
    .global_alpha_i (ga_q),
    .valid_o        (s1_valid),
    .ready_i        (s1_ready),
    .data_o         (s1_data)
  );

  tspc_tint u_tint (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  tspc_blend u_blend (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s2_valid),
    .ready_o        (s2_ready),
    .data_i         (s2_data),
    .mid_valid_o    (s3_valid),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .new_pixel_o    (new_pixel_o),
    .write_enable_o (write_enable_o)
  );

  // An empty output register must never back-pressure the input
  `TSPC_ASSERT_IMPLIES(a_empty_out_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)
  // Nothing in flight and nothing entering: no result can appear
  `TSPC_ASSERT_NEXT(a_no_phantom, clk_i, rst_ni,
    !(in_valid_i && in_ready_o) && !s1_valid && !s2_valid && !s3_valid && !out_valid_o,
    !out_valid_o)
  // The config port never stalls
  `TSPC_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)

endmodule
`default_nettype wire

>>> tb/sv/tspc_blend_monitor.sv
module tspc_blend_monitor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [31:0] texel_argb_i,
  input  wire logic [23:0] dest_pixel_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [23:0] new_pixel_i,
  input  wire logic        write_enable_i,
  output logic [31:0]      pending_o,
  output logic [31:0]      mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tspc_pkg::*;

  typedef struct packed {
    logic [23:0] pixel;
    logic        store;
  } pixel_result_t;

  logic [31:0]   tint_word_q = TintReset;
  logic [8:0]    opacity_q   = GaReset;
  logic [31:0]   pending_q   = '0;
  int unsigned   fault_count = 0;
  pixel_result_t expected_pixels[$];

  assign pending_o    = pending_q;
  assign mismatches_o = fault_count;

  // x*k/255, rounded to nearest
  function automatic logic [7:0] scale_255(input logic [7:0] x, input logic [7:0] k);
    logic [16:0] t;
    logic [16:0] s;
    t = 17'(x) * 17'(k) + 17'd128;
    s = (t + (t >> 8)) >> 8;
    return s[7:0];
  endfunction

  function automatic pixel_result_t composite_pixel(input logic [31:0] tint,
                                                    input logic [8:0]  opacity,
                                                    input logic [31:0] texel,
                                                    input logic [23:0] dst);
    logic [8:0]       ga;
    logic [16:0]      scaled;
    logic [7:0]       alpha;
    logic [7:0]       tint_ch;
    logic [2:0][7:0]  colour;
    pixel_result_t    res;
    ga    = (opacity > GaReset) ? GaReset : opacity;
    alpha = texel[31:24];
    if (ga != GaReset) begin
      scaled = 17'(alpha) * 17'(ga);
      alpha  = scaled[15:8];
    end
    if (alpha == 8'd0) begin
      res.pixel = dst;
      res.store = 1'b0;
      return res;
    end
    for (int c = 0; c < 3; c++) begin
      tint_ch = tint[8*c +: 8];
      colour[c] = (tint[31:24] == SolidTag) ? tint_ch : scale_255(texel[8*c +: 8], tint_ch);
      // only the low 8 bits of the sum are kept
      if (alpha != AlphaFull)
        colour[c] = scale_255(colour[c], alpha) + scale_255(dst[8*c +: 8], AlphaFull - alpha);
    end
    res.pixel = colour;
    res.store = 1'b1;
    return res;
  endfunction

  task automatic report_fault(input string msg);
    if (fault_count < 100) $display("%0t ns: %s", $time, msg);
    fault_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_result_t want;
    if (!rst_ni) begin
      tint_word_q = TintReset;
      opacity_q   = GaReset;
      expected_pixels.delete();
      pending_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgTintWord:    tint_word_q = cfg_data_i;
          CfgGlobalAlpha: opacity_q   = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_pixels.push_back(composite_pixel(tint_word_q, opacity_q, texel_argb_i,
                                                  dest_pixel_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report_fault($sformatf("pixel %h/%b with nothing outstanding",
                                 new_pixel_i, write_enable_i));
        end else begin
          want = expected_pixels.pop_front();
          if (write_enable_i !== want.store)
            report_fault($sformatf("write_enable: expected %b, got %b",
                                   want.store, write_enable_i));
          if (new_pixel_i !== want.pixel)
            report_fault($sformatf("new_pixel: expected %h, got %h",
                                   want.pixel, new_pixel_i));
        end
      end
      pending_q <= expected_pixels.size();
    end
  end

endmodule

>>> tb/sv/tinted_sprite_pixel_compositor_test.sv
module tinted_sprite_pixel_compositor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tspc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] texel_argb_i;
  logic [23:0] dest_pixel_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [23:0] new_pixel_o;
  logic        write_enable_o;
  logic [31:0] pending_pixels;
  logic [31:0] mismatch_total;

  bit          no_gaps = 1'b0;
  int unsigned pixels_drained = 0;

  logic [31:0] corner_tint [7] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h01FF_FFFF,
                                   32'h0100_0000, 32'h00FF_FFFF, 32'h00FF_FFFF,
                                   32'hFEFF_FFFF};
  logic [31:0] corner_opacity [7] = '{32'd0, 32'd256, 32'd511, 32'd128, 32'd1, 32'd255,
                                      32'd256};

  tinted_sprite_pixel_compositor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .texel_argb_i   (texel_argb_i),
    .dest_pixel_i   (dest_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_pixel_o    (new_pixel_o),
    .write_enable_o (write_enable_o)
  );

  tspc_blend_monitor u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .texel_argb_i   (texel_argb_i),
    .dest_pixel_i   (dest_pixel_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_pixel_i    (new_pixel_o),
    .write_enable_i (write_enable_o),
    .pending_o      (pending_pixels),
    .mismatches_o   (mismatch_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // valid stays high across back-to-back transactions
  task automatic send_pixel(input logic [31:0] texel, input logic [23:0] dst);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    texel_argb_i <= texel;
    dest_pixel_i <= dst;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels != 0);
  endtask

  task automatic program_regs(input logic [31:0] tint, input logic [31:0] opacity);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgTintWord;
    cfg_data_i  <= tint;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgGlobalAlpha;
    cfg_data_i  <= opacity;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // sink: per-pixel stall, with calm stretches of no stalling
  initial begin : sink
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (pixels_drained % 192 < 64) ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      pixels_drained++;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned len;
    logic [31:0] tint;
    logic [31:0] opacity;
    logic [31:0] rgb_word;
    logic [31:0] dest_word;
    logic [7:0]  alpha;

    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    texel_argb_i = '0;
    dest_pixel_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: untinted, full opacity
    send_pixel(32'h0012_3456, 24'hABCDEF);
    send_pixel(32'hFFFF_FFFF, 24'h000000);
    send_pixel(32'hFF00_0000, 24'hFFFFFF);
    send_pixel(32'h01FF_FFFF, 24'h000000);
    send_pixel(32'hFE80_FF00, 24'h00FF80);
    send_pixel(32'h80FF_FFFF, 24'h000000);
    send_pixel(32'h7F00_0000, 24'hFFFFFF);
    send_pixel(32'hAA55_AA55, 24'h55AA55);
    drain_pipeline();
    // solid colour, opacity above range saturates
    program_regs(32'h0112_3456, 32'd257);
    send_pixel(32'h00FF_FFFF, 24'h654321);
    send_pixel(32'hFF00_0000, 24'h000000);
    send_pixel(32'h80AB_CDEF, 24'hFFFFFF);
    drain_pipeline();
    // top byte other than the solid tag means multiply
    program_regs(32'hFFC0_FFEE, 32'd511);
    send_pixel(32'hFFFF_FFFF, 24'h000000);
    send_pixel(32'h4080_8080, 24'h7F7F7F);
    drain_pipeline();
    program_regs(32'h0000_0000, 32'd0);
    send_pixel(32'hFFFF_FFFF, 24'h123456);
    drain_pipeline();
    // opacity 1 scales even full alpha down to nothing
    program_regs(32'h02FF_00FF, 32'd1);
    send_pixel(32'hFFFF_FFFF, 24'h000000);
    drain_pipeline();
    program_regs(32'h02FF_00FF, 32'd255);
    send_pixel(32'hFFFF_FFFF, 24'h000000);
    send_pixel(32'h0180_8080, 24'hFFFFFF);
    drain_pipeline();
    program_regs(32'h01FF_FFFF, 32'd128);
    send_pixel(32'hFF00_0000, 24'h000000);
    send_pixel(32'h0200_0000, 24'hFFFFFF);
    drain_pipeline();

    sent  = 0;
    phase = 0;
    while (sent < 1950) begin
      if (phase < 7) begin
        program_regs(corner_tint[phase], corner_opacity[phase]);
      end else begin
        tint = $urandom();
        case ($urandom_range(0, 3))
          0:       tint[31:24] = SolidTag;
          1:       tint[31:24] = 8'h00;
          default: ;
        endcase
        if ($urandom_range(0, 4) == 0) tint[23:0] = 24'hFFFFFF;
        opacity = $urandom();
        case ($urandom_range(0, 3))
          0:       opacity[8:0] = GaReset;
          1:       opacity[8:0] = 9'($urandom_range(257, 511));
          default: opacity[8:0] = 9'($urandom_range(0, 255));
        endcase
        program_regs(tint, opacity);
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      len = $urandom_range(100, 180);
      repeat (len) begin
        case ($urandom_range(0, 7))
          0:       alpha = 8'd0;
          1:       alpha = AlphaFull;
          2:       alpha = 8'($urandom_range(1, 3));
          default: alpha = 8'($urandom_range(0, 255));
        endcase
        rgb_word  = $urandom();
        dest_word = $urandom();
        send_pixel({alpha, rgb_word[23:0]}, dest_word[23:0]);
      end
      sent += len;
      drain_pipeline();
      phase++;
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> tinted_sprite_pixel_compositor.f
+incdir+design
design/tspc_pkg.sv
design/tspc_alpha.sv
design/tspc_tint.sv
design/tspc_blend.sv
design/tinted_sprite_pixel_compositor.sv
tb/sv/tspc_blend_monitor.sv
tb/sv/tinted_sprite_pixel_compositor_test.sv
